>>> rtl/hkc_pkg.sv
// Shared types, key codes and constants for the hex keypad calculator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hkc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] KEY_BACK   = 8'd8;
    localparam logic [7:0] KEY_ESCAPE = 8'd27;

    localparam logic [7:0] OP_EQUALS = 8'd61;
    localparam logic [7:0] OP_ADD    = 8'd43;
    localparam logic [7:0] OP_SUB    = 8'd45;
    localparam logic [7:0] OP_MUL    = 8'd42;
    localparam logic [7:0] OP_AND    = 8'd38;
    localparam logic [7:0] OP_OR     = 8'd124;
    localparam logic [7:0] OP_XOR    = 8'd94;
    localparam logic [7:0] OP_SHL    = 8'd60;
    localparam logic [7:0] OP_SHR    = 8'd62;
    localparam logic [7:0] OP_DIV    = 8'd47;
    localparam logic [7:0] OP_MOD    = 8'd37;

    localparam logic [31:0] ENTRY_LIMIT = 32'h0000_0FFF;
    localparam logic [31:0] DIV_ZERO    = 32'hFFFF_FFFF;
    localparam logic [31:0] MOD_ZERO    = 32'h0000_FFFF;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_BACK  = 2'd0;
    localparam t_kind KIND_CLEAR = 2'd1;
    localparam t_kind KIND_DIGIT = 2'd2;
    localparam t_kind KIND_OPER  = 2'd3;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic [7:0] key;
    } t_cmd;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> rtl/hex_keypad_calculator.sv
// Top level of the hex keypad calculator: front end, command queue,
// execution unit and divider. Depends on hkc_pkg and all hkc_ modules.
//
//   Channel   Signals                                   Direction
//   in        i_in_valid, o_in_stall, i_key_code        key transfer into the block
//   out       o_out_valid, i_out_stall,                 result transfer out of the block
//             o_display_value, o_beep
//
// Most keys pass from input transfer to a valid result through the command queue
// and then the result register in the execution unit. A divide or modulo by a
// nonzero value also waits on the one-bit-per-cycle divider.
// Reset is synchronous and active low; it clears the queue and the calculator state.
// The input side keeps taking keys until the queue is full, even while a result
// waits under i_out_stall.
`timescale 1ns / 1ps
`default_nettype none

module hex_keypad_calculator #(
    parameter int QUEUE_DEPTH = hkc_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_key_code,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_display_value,
    output logic             o_beep
);
    import hkc_pkg::*;

    t_cmd     w_front_cmd;
    t_cmd     w_q_cmd;
    logic     w_push;
    logic     w_full;
    logic     w_q_valid;
    logic     w_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    hkc_front u_front (
        .i_valid    (i_in_valid),
        .i_key_code (i_key_code),
        .i_full     (w_full),
        .o_stall    (o_in_stall),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    hkc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_cmd)
    );

    hkc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    hkc_exec u_exec (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_cmd           (w_q_cmd),
        .o_pop           (w_pop),
        .o_div_req       (w_div_req),
        .i_div_rsp       (w_div_rsp),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_display_value (o_display_value),
        .o_beep          (o_beep)
    );

    a_beep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_beep |-> o_display_value > ENTRY_LIMIT)
        else $error("Beep shown with an entry that is not full.");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("Command taken from an empty queue.");

    a_done_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> !w_pop)
        else $error("Command taken while a divide result is returning.");

    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |=> !w_div_req.start)
        else $error("Divider started twice in a row.");

endmodule

`default_nettype wire

>>> rtl/hkc_front.sv
// Front end: takes key transfers and classifies each key into a command.
// Depends on hkc_pkg; feeds hkc_queue.
`timescale 1ns / 1ps
`default_nettype none

module hkc_front (
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_key_code,
    input  wire logic        i_full,
    output logic             o_stall,
    output logic             o_push,
    output hkc_pkg::t_cmd    o_cmd
);
    import hkc_pkg::*;

    always_comb begin
        o_cmd.key   = i_key_code;
        o_cmd.digit = 4'd0;
        o_cmd.kind  = KIND_OPER;
        if (i_key_code == KEY_BACK) begin
            o_cmd.kind = KIND_BACK;
        end else if (i_key_code == KEY_ESCAPE) begin
            o_cmd.kind = KIND_CLEAR;
        end else if (i_key_code >= 8'd48 && i_key_code <= 8'd57) begin
            o_cmd.kind  = KIND_DIGIT;
            o_cmd.digit = 4'(i_key_code - 8'd48);
        end else if (i_key_code >= 8'd65 && i_key_code <= 8'd70) begin
            o_cmd.kind  = KIND_DIGIT;
            o_cmd.digit = 4'(i_key_code - 8'd55);
        end else if (i_key_code >= 8'd97 && i_key_code <= 8'd102) begin
            o_cmd.kind  = KIND_DIGIT;
            o_cmd.digit = 4'(i_key_code - 8'd87);
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

`default_nettype wire

>>> rtl/hkc_queue.sv
// Small command queue between the front end and the execution unit.
// Depends on hkc_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module hkc_queue #(
    parameter int DEPTH = hkc_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hkc_pkg::t_cmd i_data,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output hkc_pkg::t_cmd      o_data
);
    import hkc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hkc_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on hkc_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none

module hkc_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hkc_pkg::t_div_req i_req,
    output hkc_pkg::t_div_rsp      o_rsp
);
    import hkc_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_count;
    logic [31:0] r_quot;
    logic [31:0] r_rem;
    logic [31:0] r_div;

    logic [32:0] rem_sh;
    logic [32:0] sub_val;
    logic        ge;
    logic [31:0] new_rem;

    always_comb begin
        rem_sh  = {r_rem, r_quot[31]};
        sub_val = rem_sh - {1'b0, r_div};
        ge      = (rem_sh >= {1'b0, r_div});
        new_rem = ge ? sub_val[31:0] : rem_sh[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_count == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot  <= i_req.dividend;
            r_rem   <= '0;
            r_div   <= i_req.divisor;
            r_count <= '0;
        end else if (r_busy) begin
            r_quot  <= {r_quot[30:0], ge};
            r_rem   <= new_rem;
            r_count <= r_count + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/hkc_exec.sv
// Execution unit: holds the calculator state, carries out queued commands
// and drives the result register. Depends on hkc_pkg; drives hkc_divider through o_div_req.
`timescale 1ns / 1ps
`default_nettype none

module hkc_exec (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire hkc_pkg::t_cmd     i_cmd,
    output logic                   o_pop,
    output hkc_pkg::t_div_req      o_div_req,
    input  wire hkc_pkg::t_div_rsp i_div_rsp,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic [31:0]            o_display_value,
    output logic                   o_beep
);
    import hkc_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic        r_state, n_state;
    logic [31:0] r_entry, n_entry;
    logic [31:0] r_first, n_first;
    logic [7:0]  r_pend, n_pend;
    logic        r_new, n_new;
    logic        r_is_mod, n_is_mod;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_value, n_out_value;
    logic        r_out_beep, n_out_beep;

    logic [31:0] base;
    logic        defer;
    logic        beep;

    assign o_pop = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_entry     = r_entry;
        n_first     = r_first;
        n_pend      = r_pend;
        n_new       = r_new;
        n_is_mod    = r_is_mod;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        n_out_beep  = r_out_beep;
        base        = r_new ? 32'd0 : r_entry;
        defer       = 1'b0;
        beep        = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_first;
        o_div_req.divisor  = r_entry;

        if (o_pop) begin
            case (i_cmd.kind)
                KIND_BACK: begin
                    n_entry = r_entry >> 4;
                end
                KIND_CLEAR: begin
                    n_entry = 32'd0;
                end
                KIND_DIGIT: begin
                    if (r_new) begin
                        n_first = r_entry;
                    end
                    n_new = 1'b0;
                    if (base <= ENTRY_LIMIT) begin
                        n_entry = {base[27:0], i_cmd.digit};
                    end else begin
                        beep = 1'b1;
                    end
                end
                default: begin
                    n_new  = 1'b1;
                    n_pend = i_cmd.key;
                    if (!r_new) begin
                        case (r_pend)
                            OP_EQUALS: n_entry = r_entry;
                            OP_ADD:    n_entry = r_first + r_entry;
                            OP_SUB:    n_entry = r_first - r_entry;
                            OP_MUL:    n_entry = 32'(r_first * r_entry);
                            OP_AND:    n_entry = r_first & r_entry;
                            OP_OR:     n_entry = r_first | r_entry;
                            OP_XOR:    n_entry = r_first ^ r_entry;
                            OP_SHL: begin
                                n_entry = (r_entry[31:5] != '0) ? 32'd0
                                        : r_first << r_entry[4:0];
                            end
                            OP_SHR: begin
                                n_entry = (r_entry[31:5] != '0) ? 32'd0
                                        : r_first >> r_entry[4:0];
                            end
                            OP_DIV, OP_MOD: begin
                                if (r_entry == 32'd0) begin
                                    n_entry = (r_pend == OP_DIV) ? DIV_ZERO : MOD_ZERO;
                                end else begin
                                    defer           = 1'b1;
                                    o_div_req.start = 1'b1;
                                    n_is_mod        = (r_pend == OP_MOD);
                                    n_state         = S_DIV;
                                end
                            end
                            default:   n_entry = 32'd0;
                        endcase
                    end
                end
            endcase
            if (!defer) begin
                n_out_valid = 1'b1;
                n_out_value = n_entry;
                n_out_beep  = beep;
            end
        end else if (r_state == S_DIV && i_div_rsp.done) begin
            n_entry     = r_is_mod ? i_div_rsp.rem : i_div_rsp.quot;
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_out_value = n_entry;
            n_out_beep  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entry     <= '0;
            r_first     <= '0;
            r_pend      <= OP_EQUALS;
            r_new       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_entry     <= n_entry;
            r_first     <= n_first;
            r_pend      <= n_pend;
            r_new       <= n_new;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_mod    <= n_is_mod;
        r_out_value <= n_out_value;
        r_out_beep  <= n_out_beep;
    end

    assign o_out_valid     = r_out_valid;
    assign o_display_value = r_out_value;
    assign o_beep          = r_out_beep;

endmodule

`default_nettype wire
